@@ src/dtwcp_pkg.sv @@
// ----------------------------------------------------------------------------
// dtwcp_pkg
// shared types and constants of the dynamic time warping cost path step block
// ----------------------------------------------------------------------------
package dtwcp_pkg;

    // field widths fixed by the data format
    localparam int LC_W       = 16;   // local cost, unsigned Q8.8
    localparam int WEIGHT_W   = 8;    // step weight, unsigned Q4.4
    localparam int PROD_W     = LC_W + WEIGHT_W;
    localparam int COST_W     = 40;   // accumulated cost, unsigned Q28.12
    localparam int STEP_IDX_W = 2;
    localparam int SHIFT_W    = 2;
    localparam int STEP_REGS  = 4;    // step table registers on the port
    localparam int STEP_CNT_W = 3;
    localparam int CFG_CNT_W  = 9;    // row and column count registers
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [COST_W-1:0] COST_INF = {COST_W{1'b1}};

    // packed step register layout
    localparam int STEP_DI_HI = 11;
    localparam int STEP_DI_LO = 10;
    localparam int STEP_DJ_HI = 9;
    localparam int STEP_DJ_LO = 8;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_COUNT  = 3'd0,
        CFG_COL_COUNT  = 3'd1,
        CFG_STEP_COUNT = 3'd2,
        CFG_STEP_ZERO  = 3'd3,
        CFG_STEP_ONE   = 3'd4,
        CFG_STEP_TWO   = 3'd5,
        CFG_STEP_THREE = 3'd6
    } t_cfg_idx;

    // cell sequencer
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [LC_W-1:0] local_cost;
    } t_in;

    typedef struct packed {
        logic [COST_W-1:0]     accumulated_cost;
        logic [STEP_IDX_W-1:0] best_step;
        logic                  no_predecessor;
        logic                  last_cell;
    } t_out;

endpackage

@@ src/dtwcp_stream_if.sv @@
// ----------------------------------------------------------------------------
// dtwcp_stream_if
// valid / ready channel carrying one payload struct per transaction
// ----------------------------------------------------------------------------
interface dtwcp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/dtw_cost_path_step.sv @@
// ----------------------------------------------------------------------------
// dtw_cost_path_step
// dynamic time warping matrix fill with a configurable step table
// ----------------------------------------------------------------------------
// Usage: program row_count, col_count, step_count and the step table through
// the write port while the block is idle, then stream local costs row by row
// on i_in. Each transaction on i_in yields one transaction on o_out with the
// accumulated cost, the winning step and the origin/unreachable and last-cell
// flags. After the last cell the position wraps and a new matrix starts.
// After acceptance the block makes one predecessor read for each step in
// use (0 to 4 steps; none for the origin cell), then loads the output
// register, and it takes no new cell before it is through with the last.
// The pace is set by the single read port of the cost window memory, with
// the multiply done alongside each read and the add-compare in the cycle
// after it.
// Reset clears the position to the origin and the configuration registers
// to their defaults; the window memory is not cleared, a cell only reads
// entries of earlier cells of the same matrix. A stalled receiver holds the
// result in the output register; the next cell may still be accepted and
// waits in its final state until the output register frees.
// ----------------------------------------------------------------------------
module dtw_cost_path_step
    import dtwcp_pkg::*;
#(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int MAX_STEPS = 4,
    parameter int MAX_SHIFT = 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    dtwcp_stream_if.sink          i_in,
    dtwcp_stream_if.source        o_out
);

    localparam int WIN_ROWS = MAX_SHIFT + 1;
    localparam int DEPTH    = WIN_ROWS * MAX_COLS;
    localparam int AW       = $clog2(DEPTH);
    localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CLW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int SW       = $clog2(WIN_ROWS);
    localparam int PW       = (RW > CLW) ? RW : CLW;
    localparam int CNT_W    = (PW + 1 > CFG_CNT_W) ? PW + 1 : CFG_CNT_W;

    // configuration registers
    logic [CFG_CNT_W-1:0]  r_row_count;
    logic [CFG_CNT_W-1:0]  r_col_count;
    logic [STEP_CNT_W-1:0] r_step_count;
    logic [CFG_DATA_W-1:0] r_step [STEP_REGS];

    // position and control
    t_state                r_state, n_state;
    logic [RW-1:0]         r_row;
    logic [CLW-1:0]        r_col;
    logic [SW-1:0]         r_slot;
    logic [STEP_IDX_W-1:0] r_k;
    logic                  r_ev_valid;
    logic                  r_out_valid;

    // datapath
    logic [LC_W-1:0]       r_lc;
    logic [PROD_W-1:0]     r_prod;
    logic [STEP_IDX_W-1:0] r_ev_k;
    logic [COST_W-1:0]     r_best, n_best;
    logic [STEP_IDX_W-1:0] r_best_k, n_best_k;
    logic [COST_W-1:0]     r_rd_data;
    t_out                  r_out;

    logic [COST_W-1:0]     r_mem [DEPTH];

    logic                  in_ready, in_acc, fin_go, issue_last, origin;
    logic                  usable, none, row_last, col_last;
    logic [STEP_CNT_W-1:0] nsteps;
    logic [CNT_W-1:0]      rows_eff, cols_eff;
    logic [CFG_DATA_W-1:0] step;
    logic [SHIFT_W-1:0]    di, dj;
    logic [SW-1:0]         pred_slot;
    logic [AW-1:0]         rd_addr, wr_addr;
    logic [COST_W:0]       cand_sum;
    logic [COST_W-1:0]     cand;

    // configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count  <= CFG_CNT_W'(1);
            r_col_count  <= CFG_CNT_W'(1);
            r_step_count <= '0;
            for (int i = 0; i < STEP_REGS; i++) r_step[i] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_COUNT:  r_row_count  <= i_cfg_data[CFG_CNT_W-1:0];
                CFG_COL_COUNT:  r_col_count  <= i_cfg_data[CFG_CNT_W-1:0];
                CFG_STEP_COUNT: r_step_count <= i_cfg_data[STEP_CNT_W-1:0];
                CFG_STEP_ZERO:  r_step[0]    <= i_cfg_data;
                CFG_STEP_ONE:   r_step[1]    <= i_cfg_data;
                CFG_STEP_TWO:   r_step[2]    <= i_cfg_data;
                CFG_STEP_THREE: r_step[3]    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamped counts
    always_comb begin
        if (r_row_count == '0)
            rows_eff = CNT_W'(1);
        else if (CNT_W'(r_row_count) > CNT_W'(MAX_ROWS))
            rows_eff = CNT_W'(MAX_ROWS);
        else
            rows_eff = CNT_W'(r_row_count);
        if (r_col_count == '0)
            cols_eff = CNT_W'(1);
        else if (CNT_W'(r_col_count) > CNT_W'(MAX_COLS))
            cols_eff = CNT_W'(MAX_COLS);
        else
            cols_eff = CNT_W'(r_col_count);
        if (r_step_count > STEP_CNT_W'(MAX_STEPS))
            nsteps = STEP_CNT_W'(MAX_STEPS);
        else
            nsteps = r_step_count;
    end

    // step decode and predecessor address
    always_comb begin
        step   = r_step[r_k];
        di     = step[STEP_DI_HI:STEP_DI_LO];
        dj     = step[STEP_DJ_HI:STEP_DJ_LO];
        usable = !(di == '0 && dj == '0)
              && di <= SHIFT_W'(MAX_SHIFT) && dj <= SHIFT_W'(MAX_SHIFT)
              && (PW + 2)'(di) <= (PW + 2)'(r_row)
              && (PW + 2)'(dj) <= (PW + 2)'(r_col);
        if ((SW + 2)'(r_slot) >= (SW + 2)'(di))
            pred_slot = SW'((SW + 2)'(r_slot) - (SW + 2)'(di));
        else
            pred_slot = SW'((SW + 2)'(r_slot) + (SW + 2)'(WIN_ROWS) - (SW + 2)'(di));
        rd_addr = AW'(pred_slot) * AW'(MAX_COLS) + AW'(r_col - CLW'(dj));
        wr_addr = AW'(r_slot) * AW'(MAX_COLS) + AW'(r_col);
    end

    // candidate evaluation, in the cycle after the read
    always_comb begin
        cand_sum = {1'b0, r_rd_data} + (COST_W + 1)'(r_prod);
        cand     = (cand_sum >= (COST_W + 1)'(COST_INF)) ? COST_INF : cand_sum[COST_W-1:0];
        n_best   = r_best;
        n_best_k = r_best_k;
        if (r_ev_valid && r_rd_data != COST_INF && cand < r_best) begin
            n_best   = cand;
            n_best_k = r_ev_k;
        end
    end

    // position flags
    always_comb begin
        origin   = (r_row == '0) && (r_col == '0);
        row_last = (CNT_W'(r_row) + CNT_W'(1)) >= rows_eff;
        col_last = (CNT_W'(r_col) + CNT_W'(1)) >= cols_eff;
        none     = origin || (n_best == COST_INF);
    end

    // sequencer next state and handshake
    always_comb begin
        in_ready   = (r_state == ST_IDLE);
        in_acc     = in_ready && i_in.valid;
        issue_last = (STEP_CNT_W'(r_k) + STEP_CNT_W'(1)) >= nsteps;
        fin_go     = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);
        n_state    = r_state;
        case (r_state)
            ST_IDLE: if (in_acc) n_state = (origin || nsteps == '0) ? ST_FIN : ST_RUN;
            ST_RUN:  if (issue_last) n_state = ST_FIN;
            ST_FIN:  if (fin_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    assign i_in.ready  = in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    // control registers: position, step issue, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_slot      <= '0;
            r_ev_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ev_valid <= (r_state == ST_RUN) && usable;
            if (fin_go) begin
                r_out_valid <= 1'b1;
                if (col_last) begin
                    r_col <= '0;
                    if (row_last) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= r_row + RW'(1);
                        r_slot <= (r_slot == SW'(WIN_ROWS - 1)) ? '0 : r_slot + SW'(1);
                    end
                end else begin
                    r_col <= r_col + CLW'(1);
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_lc     <= i_in.data.local_cost;
            r_best   <= origin ? {{(COST_W - LC_W - 4){1'b0}}, i_in.data.local_cost, 4'b0000}
                               : COST_INF;
            r_best_k <= '0;
            r_k      <= '0;
        end else if (r_state == ST_RUN) begin
            r_k      <= r_k + STEP_IDX_W'(1);
            r_prod   <= PROD_W'(r_lc) * PROD_W'(step[WEIGHT_W-1:0]);
            r_ev_k   <= r_k;
            r_best   <= n_best;
            r_best_k <= n_best_k;
        end else if (r_state == ST_FIN) begin
            r_best   <= n_best;
            r_best_k <= n_best_k;
        end
        if (fin_go) begin
            r_out.accumulated_cost <= n_best;
            r_out.best_step        <= none ? '0 : n_best_k;
            r_out.no_predecessor   <= none;
            r_out.last_cell        <= row_last && col_last;
        end
    end

    // cost window memory: one read port, one write port
    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) r_rd_data <= r_mem[rd_addr];
        if (fin_go)            r_mem[wr_addr] <= n_best;
    end

endmodule

@@ src/dtwcp_checker.sv @@
// ----------------------------------------------------------------------------
// dtwcp_checker
// port-level checks of the cost path step block, bound to the top level
// ----------------------------------------------------------------------------
module dtwcp_checker
    import dtwcp_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input t_out i_out_data
);

    // a stalled result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // one cell at a time: no new transaction right after one is taken
    a_one_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken in consecutive cycles");

    // no winning step without a predecessor
    a_no_pred_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.no_predecessor |-> i_out_data.best_step == '0)
        else $error("step reported for cell without predecessor");

    // a finite cost without predecessor is the origin: a scaled local cost
    a_origin_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.no_predecessor && i_out_data.accumulated_cost != COST_INF
        |-> i_out_data.accumulated_cost[3:0] == 4'b0000
         && i_out_data.accumulated_cost[COST_W-1:LC_W+4] == '0)
        else $error("origin cost out of range");

endmodule

bind dtw_cost_path_step dtwcp_checker u_dtwcp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
